// File: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg: shared codes and types of the escaped frame receiver
// Framing codes, receive modes, status codes, register indexes and the
// structs that pass state and results between the step logic and the top.
// ----------------------------------------------------------------------------
package efr_pkg;

	localparam logic [7:0] START_CODE = 8'h56;
	localparam logic [7:0] END_CODE   = 8'h9E;
	localparam logic [7:0] ESC_CODE   = 8'hCC;
	localparam logic [7:0] START_INV  = ~START_CODE;
	localparam logic [7:0] END_INV    = ~END_CODE;
	localparam logic [7:0] ESC_INV    = ~ESC_CODE;

	localparam int unsigned RAW_W  = 12;
	localparam int unsigned TICK_W = 24;

	// receive modes
	localparam logic [1:0] MODE_HUNT = 2'd0;
	localparam logic [1:0] MODE_BODY = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_DROP = 2'd3;

	// status codes
	localparam logic [2:0] ST_IN_FRAME = 3'd0;
	localparam logic [2:0] ST_GOOD     = 3'd1;
	localparam logic [2:0] ST_BAD_ESC  = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;

	// item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_MAX_RAW_LENGTH = 1'b0;
	localparam logic REG_TIMEOUT_TICKS  = 1'b1;

	localparam logic [RAW_W-1:0]  MAX_RAW_LENGTH_RST = 12'd2048;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST  = 24'd1000000;

	typedef struct packed {
		logic [1:0]        mode;
		logic [RAW_W-1:0]  raw_count;
		logic [TICK_W-1:0] tick_count;
	} rx_state_t;

	typedef struct packed {
		logic       present;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       frame_last;
		logic [2:0] status;
	} rx_result_t;

endpackage

// File: rtl/escaped_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver_unit: byte-stuffed frame receiver
// Hunts for the start code, unescapes body bytes, reports frame end and
// errors (bad escape, overflow, timeout) on a result stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one transfer per received byte (s_tuser = 0, byte in
//   s_tdata) or per time tick (s_tuser = 1, s_tdata ignored).
//   Master stream m_*: zero or one transfer per input transfer. m_tdata is
//   the decoded byte, m_tuser carries data_valid and status, m_tlast marks
//   frame end or an error report. Items that cause no result vanish.
//   Config channel cfg_*: index 0 writes max_raw_length, index 1 writes
//   timeout_ticks; always ready, write only while the block is idle.
// Timing:
//   One transfer per cycle sustained while m_tready is high. An input
//   transfer reaches m_* through an input register, then the decode and
//   state update feeding the output register.
// Reset:
//   arst_n clears the pipeline, returns to hunting with zero counters and
//   loads the register defaults (2048 bytes, 1000000 ticks).
// Stall:
//   While m_tready is low with a result pending, the input register holds
//   and s_tready drops once it is full; no item is lost or reordered.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tuser,   // [0] kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic [3:0]  m_tuser,   // [0] data_valid, [3:1] status
	output logic        m_tlast,   // frame_last
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	// configuration registers
	logic [efr_pkg::RAW_W-1:0]  max_raw_length_q;
	logic [efr_pkg::TICK_W-1:0] timeout_ticks_q;

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// receive state and result register
	efr_pkg::rx_state_t  state_q;
	efr_pkg::rx_state_t  state_next;
	efr_pkg::rx_result_t step_res;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                out_dvalid_q;
	logic                out_last_q;
	logic [2:0]          out_status_q;

	logic out_free;
	logic advance_s1;

	// the output slot frees when it is empty or being drained this cycle
	assign out_free   = !out_valid_q || m_tready;
	assign advance_s1 = valid_s1 && out_free;
	assign s_tready   = !valid_s1 || out_free;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_raw_length_q <= efr_pkg::MAX_RAW_LENGTH_RST;
			timeout_ticks_q  <= efr_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				efr_pkg::REG_MAX_RAW_LENGTH: max_raw_length_q <= cfg_data[efr_pkg::RAW_W-1:0];
				efr_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage: take a transfer whenever the register is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	efr_step u_step (
		.cur            (state_q),
		.max_raw_length (max_raw_length_q),
		.timeout_ticks  (timeout_ticks_q),
		.kind           (kind_s1),
		.byte_in        (byte_s1),
		.nxt            (state_next),
		.res            (step_res)
	);

	// advance the receive state once per item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_next;
		end
	end

	// result register: load a result, or drop the valid once drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && step_res.present;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && step_res.present) begin
			out_byte_q   <= step_res.data_byte;
			out_dvalid_q <= step_res.data_valid;
			out_last_q   <= step_res.frame_last;
			out_status_q <= step_res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_status_q, out_dvalid_q};
	assign m_tlast  = out_last_q;

	// hunting always starts a frame with an empty byte count
	a_hunt_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == efr_pkg::MODE_HUNT |-> state_q.raw_count == '0)
		else $error("raw count not clear while hunting");

	// a frame end or error leaves the receiver hunting or dropping
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && step_res.present && step_res.frame_last |=>
		(state_q.mode == efr_pkg::MODE_HUNT || state_q.mode == efr_pkg::MODE_DROP))
		else $error("receiver kept collecting after frame end or error");

	// a decoded byte never carries an end or error status
	a_data_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast && m_tuser[3:1] == efr_pkg::ST_IN_FRAME)
		else $error("decoded byte with end or error status");

	// a status-only result carries a zero data byte
	a_status_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'd0)
		else $error("status report with stray data");

endmodule

// File: rtl/efr_step.sv
// ----------------------------------------------------------------------------
// efr_step: per-item next-state and result logic
// Decodes one byte or tick against the current receive state and yields
// the next state plus at most one result.
// ----------------------------------------------------------------------------
module efr_step (
	input  efr_pkg::rx_state_t            cur,
	input  logic [efr_pkg::RAW_W-1:0]     max_raw_length,
	input  logic [efr_pkg::TICK_W-1:0]    timeout_ticks,
	input  logic                          kind,
	input  logic [7:0]                    byte_in,
	output efr_pkg::rx_state_t            nxt,
	output efr_pkg::rx_result_t           res
);

	logic [efr_pkg::TICK_W:0] tick_next;
	logic [efr_pkg::RAW_W:0]  raw_next;

	assign tick_next = {1'b0, cur.tick_count} + 1'b1;
	assign raw_next  = {1'b0, cur.raw_count} + 1'b1;

	always_comb begin
		nxt = cur;
		res = '0;
		if (kind == efr_pkg::KIND_TICK) begin
			if (tick_next >= {1'b0, timeout_ticks}) begin
				nxt = '0;
				nxt.mode = efr_pkg::MODE_HUNT;
				// a dropped frame already reported its error
				if (cur.mode != efr_pkg::MODE_DROP) begin
					res.present    = 1'b1;
					res.frame_last = 1'b1;
					res.status     = efr_pkg::ST_TIMEOUT;
				end
			end else begin
				nxt.tick_count = tick_next[efr_pkg::TICK_W-1:0];
			end
		end else begin
			unique case (cur.mode)
				efr_pkg::MODE_HUNT: begin
					if (byte_in == efr_pkg::START_CODE) begin
						nxt.mode      = efr_pkg::MODE_BODY;
						nxt.raw_count = '0;
					end
				end
				efr_pkg::MODE_DROP: begin
					if (byte_in == efr_pkg::END_CODE) begin
						nxt = '0;
						nxt.mode = efr_pkg::MODE_HUNT;
					end
				end
				default: begin
					if (byte_in == efr_pkg::END_CODE) begin
						nxt = '0;
						nxt.mode = efr_pkg::MODE_HUNT;
						res.present    = 1'b1;
						res.frame_last = 1'b1;
						res.status     = efr_pkg::ST_GOOD;
					end else if (raw_next >= {1'b0, max_raw_length}) begin
						nxt = '0;
						nxt.mode = efr_pkg::MODE_HUNT;
						res.present    = 1'b1;
						res.frame_last = 1'b1;
						res.status     = efr_pkg::ST_OVERFLOW;
					end else begin
						nxt.raw_count = raw_next[efr_pkg::RAW_W-1:0];
						if (cur.mode == efr_pkg::MODE_ESC) begin
							res.present = 1'b1;
							nxt.mode    = efr_pkg::MODE_BODY;
							res.data_valid = 1'b1;
							if (byte_in == efr_pkg::START_INV) begin
								res.data_byte = efr_pkg::START_CODE;
							end else if (byte_in == efr_pkg::END_INV) begin
								res.data_byte = efr_pkg::END_CODE;
							end else if (byte_in == efr_pkg::ESC_INV) begin
								res.data_byte = efr_pkg::ESC_CODE;
							end else begin
								nxt.mode       = efr_pkg::MODE_DROP;
								res.data_valid = 1'b0;
								res.frame_last = 1'b1;
								res.status     = efr_pkg::ST_BAD_ESC;
							end
						end else if (byte_in == efr_pkg::ESC_CODE) begin
							nxt.mode = efr_pkg::MODE_ESC;
						end else begin
							res.present    = 1'b1;
							res.data_valid = 1'b1;
							res.data_byte  = byte_in;
						end
					end
				end
			endcase
		end
	end

endmodule
